### rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int DEPTH = 64;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int POS_W = 7;
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int ST_W       = 2;
    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  key;
    } t_bcast;

endpackage

`default_nettype wire

### rtl/core/ple_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_cell (
    input  wire                           i_clk,
    input  wire  [ple_pkg::IDX_W-1:0]     i_idx,
    input  wire  ple_pkg::t_bcast         i_bcast,
    input  wire  [ple_pkg::VAL_W-1:0]     i_left,
    input  wire  [ple_pkg::VAL_W-1:0]     i_right,
    output logic [ple_pkg::VAL_W-1:0]     o_value,
    output logic                          o_match
);

    logic [ple_pkg::VAL_W-1:0] r_value;
    logic [ple_pkg::VAL_W-1:0] n_value;
    logic                      w_eq;
    logic                      w_gt;
    logic                      w_live;

    assign w_eq   = (i_idx == i_bcast.idx);
    assign w_gt   = (i_idx > i_bcast.idx);
    assign w_live = (ple_pkg::LEN_W'(i_idx) < i_bcast.len);

    always_comb begin
        n_value = r_value;
        if (i_bcast.ins) begin
            if (w_eq) begin
                n_value = i_bcast.key;
            end else if (w_gt) begin
                n_value = i_left;
            end
        end else if (i_bcast.del && (w_eq || w_gt)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = w_live && (r_value == i_bcast.key);

endmodule

`default_nettype wire

### rtl/core/ple_penc.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_penc (
    input  wire  [ple_pkg::DEPTH-1:0]   i_match,
    output logic [ple_pkg::LEN_W-1:0]   o_pos
);

    always_comb begin
        o_pos = '0;
        for (int i = ple_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_pos = ple_pkg::LEN_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Signals               | Payload
// ---------+-----+-----------------------+-----------------------------------------
// command  | in  | i_s_tvalid/o_s_tready | tuser: cmd; tdata: value, position
// result   | out | o_m_tvalid/i_m_tready | tdata: found_position, list_length, status
//
// One transfer per cycle: every cell shifts, loads or compares in the cycle
// the command is taken, and the result lands in the output register next edge.
// Search goes through the cell compares and the match priority encoder.
// The output register is freed in the same cycle it is taken, so a stalled
// result holds the command channel only while i_m_tready is low.
// Reset clears the list length and the output valid; cell contents are not reset.

module positional_list_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  wire  [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [6:0] found_position, [13:7] list_length,
                                     // [15:14] status
);

    localparam int N = ple_pkg::DEPTH;

    logic [ple_pkg::LEN_W-1:0] r_len;
    logic [ple_pkg::LEN_W-1:0] n_len;
    logic                      r_out_valid;
    logic [ple_pkg::POS_W-1:0] r_found;
    logic [ple_pkg::POS_W-1:0] r_len_out;
    logic [ple_pkg::ST_W-1:0]  r_status;

    logic                      w_accept;
    logic [ple_pkg::CMD_W-1:0] w_cmd;
    logic [ple_pkg::VAL_W-1:0] w_key;
    logic [ple_pkg::POS_W-1:0] w_pos;
    logic [ple_pkg::CMP_W-1:0] w_pos_c;
    logic [ple_pkg::CMP_W-1:0] w_len_c;
    logic [ple_pkg::CMP_W-1:0] w_pos_m1;
    logic [ple_pkg::ST_W-1:0]  w_status;
    logic [ple_pkg::LEN_W-1:0] w_found;
    logic [ple_pkg::POS_W-1:0] w_found_out;
    logic                      w_do_ins;
    logic                      w_do_del;
    ple_pkg::t_bcast           w_bcast;

    logic [ple_pkg::VAL_W-1:0] w_value [N];
    logic [N-1:0]              w_match;

    assign w_cmd    = i_s_tuser;
    assign w_key    = i_s_tdata[31:0];
    assign w_pos    = i_s_tdata[38:32];
    assign w_pos_c  = ple_pkg::CMP_W'(w_pos);
    assign w_len_c  = ple_pkg::CMP_W'(r_len);
    assign w_pos_m1 = w_pos_c - ple_pkg::CMP_W'(1);

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        w_status = ple_pkg::ST_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        n_len    = r_len;
        unique case (w_cmd)
            ple_pkg::CMD_INSERT: begin
                if (r_len == ple_pkg::LEN_W'(N)) begin
                    w_status = ple_pkg::ST_FULL;
                end else if (w_pos_c == '0 || w_pos_c > w_len_c + ple_pkg::CMP_W'(1)) begin
                    w_status = ple_pkg::ST_BAD_POS;
                end else begin
                    w_do_ins = 1'b1;
                    n_len    = r_len + ple_pkg::LEN_W'(1);
                end
            end
            ple_pkg::CMD_DELETE: begin
                if (r_len == '0) begin
                    w_status = ple_pkg::ST_EMPTY;
                end else if (w_pos_c == '0 || w_pos_c > w_len_c) begin
                    w_status = ple_pkg::ST_BAD_POS;
                end else begin
                    w_do_del = 1'b1;
                    n_len    = r_len - ple_pkg::LEN_W'(1);
                end
            end
            ple_pkg::CMD_SEARCH: begin
                if (r_len == '0) begin
                    w_status = ple_pkg::ST_EMPTY;
                end
            end
            default: begin
                w_status = ple_pkg::ST_OK;
            end
        endcase
    end

    assign w_bcast.ins = w_accept && w_do_ins;
    assign w_bcast.del = w_accept && w_do_del;
    assign w_bcast.idx = w_pos_m1[ple_pkg::IDX_W-1:0];
    assign w_bcast.len = r_len;
    assign w_bcast.key = w_key;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [ple_pkg::VAL_W-1:0] w_left;
        logic [ple_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_key;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (ple_pkg::IDX_W'(g)),
            .i_bcast (w_bcast),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_match (w_match[g])
        );
    end

    ple_penc u_penc (
        .i_match (w_match),
        .o_pos   (w_found)
    );

    assign w_found_out = (w_cmd == ple_pkg::CMD_SEARCH)
                       ? ple_pkg::POS_W'(w_found) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found   <= w_found_out;
            r_len_out <= ple_pkg::POS_W'(n_len);
            r_status  <= w_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_status, r_len_out, r_found};

endmodule

`default_nettype wire

### test/list_result_checker.sv
`timescale 1ns / 1ps

module list_result_checker
    import ple_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [39:0] i_s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  wire  [1:0]  i_s_tuser,   // [1:0] cmd
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,   // [6:0] found_position, [13:7] list_length,
                                     // [15:14] status
    output int          o_mismatch_count,
    output int          o_pending,
    output int unsigned o_list_len
);

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] list_len;
        logic [POS_W-1:0] found_pos;
    } t_list_result;

    logic [VAL_W-1:0] shadow_vals [DEPTH];
    int unsigned      shadow_len;
    t_list_result     expected_results [$];
    t_list_result     predicted;
    t_list_result     observed;

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
        o_list_len       = 0;
        shadow_len       = 0;
    end

    function automatic t_list_result apply_command(
        input logic [CMD_W-1:0] cmd,
        input logic [VAL_W-1:0] val,
        input logic [POS_W-1:0] pos
    );
        t_list_result r;
        int unsigned  p;
        int           i;
        r = '0;
        p = pos;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > shadow_len + 1) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = shadow_len; i >= int'(p); i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[p-1] = val;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = p - 1; i + 1 < int'(shadow_len); i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
            CMD_SEARCH: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 0; i < int'(shadow_len); i++)
                        if (r.found_pos == 0 && shadow_vals[i] == val)
                            r.found_pos = POS_W'(i + 1);
                end
            end
            default: ;
        endcase
        r.list_len = POS_W'(shadow_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_command(i_s_tuser, i_s_tdata[31:0],
                                                         i_s_tdata[38:32]));
            if (i_m_tvalid && i_m_tready) begin
                observed = i_m_tdata;
                if (expected_results.size() == 0) begin
                    if (o_mismatch_count < 10)
                        $display("%0t: unexpected result: found=%0d len=%0d status=%0d",
                                 $realtime, observed.found_pos, observed.list_len,
                                 observed.status);
                    o_mismatch_count++;
                end else begin
                    predicted = expected_results.pop_front();
                    if (observed.found_pos !== predicted.found_pos ||
                        observed.list_len  !== predicted.list_len  ||
                        observed.status    !== predicted.status) begin
                        if (o_mismatch_count < 10)
                            $display("%0t: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, predicted.found_pos, predicted.list_len,
                                     predicted.status, observed.found_pos,
                                     observed.list_len, observed.status);
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_pending  = expected_results.size();
        o_list_len = shadow_len;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // [31:0] value, [38:32] position, [39] zero
    logic [1:0]  i_s_tuser;   // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [6:0] found_position, [13:7] list_length, [15:14] status

    int          mismatch_count;
    int          pending;
    int unsigned list_len;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    int          cycle_count;

    positional_list_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    list_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending),
        .o_list_len       (list_len)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: alternate between open, random and mostly stalled stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 50);
        end
        stall_left--;
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            default: i_m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, pos, val};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return VAL_W'(int'($urandom_range(0, 15)) - 8);
        else if (r < 45)
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = (cmd == CMD_INSERT) ? list_len + 1 : ((list_len == 0) ? 1 : list_len);
        if (r < 20)
            return 1;
        else if (r < 40)
            return POS_W'(hi);
        else if (r < 75)
            return POS_W'($urandom_range(1, hi));
        else if (r < 82)
            return 0;
        else if (r < 90)
            return POS_W'((hi + 1 > 127) ? 127 : hi + 1);
        return POS_W'($urandom_range(0, 127));
    endfunction

    // phase 0 grows the list, phase 1 shrinks it, phase 2 mixes
    function automatic logic [CMD_W-1:0] pick_command(input int phase_kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return CMD_UNUSED;
        case (phase_kind)
            0:       return (r < 75) ? CMD_INSERT : (r < 85) ? CMD_DELETE : CMD_SEARCH;
            1:       return (r < 75) ? CMD_DELETE : (r < 85) ? CMD_INSERT : CMD_SEARCH;
            default: return (r < 40) ? CMD_INSERT : (r < 70) ? CMD_DELETE : CMD_SEARCH;
        endcase
    endfunction

    initial begin
        int               sent;
        int               phase_count;
        int               phase_kind;
        int               phase_items;
        int               k;
        logic [CMD_W-1:0] cmd;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_left  = 0;
        cycle_count = 0;
        sent        = 0;
        phase_count = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_SEARCH, 32'h0000_0005, 7'd0);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd1);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd0);
        send_item(CMD_INSERT, 32'h1111_1111, 7'd0);
        send_item(CMD_INSERT, 32'h2222_2222, 7'd2);
        send_item(CMD_INSERT, 32'h8000_0000, 7'd1);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 7'd2);
        send_item(CMD_INSERT, 32'h0000_0000, 7'd1);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 7'd4);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 7'd1);
        send_item(CMD_SEARCH, 32'h7FFF_FFFF, 7'd127);
        send_item(CMD_SEARCH, 32'hFFFF_FFFF, 7'd0);
        send_item(CMD_SEARCH, 32'h1234_5678, 7'd3);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd6);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd0);
        send_item(CMD_INSERT, 32'h3333_3333, 7'd127);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 7'd127);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd5);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd1);
        send_item(CMD_INSERT, 32'h5A5A_5A5A, 7'd3);
        send_item(CMD_DELETE, 32'h0000_0000, 7'd2);
        send_item(CMD_SEARCH, 32'h8000_0000, 7'd64);
        hold_until_drained();

        while (sent < RANDOM_ITEMS) begin
            phase_kind  = $urandom_range(0, 2);
            phase_items = $urandom_range(20, 120);
            for (k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
                cmd = pick_command(phase_kind);
                send_item(cmd, pick_value(), pick_position(cmd));
                sent++;
            end
            phase_count++;
            if (phase_count % 5 == 0)
                hold_until_drained();
        end

        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
